### design/lpfb_pkg.sv
// shared types and constants for the palette frame bit parser
`timescale 1ns / 1ps
`default_nettype none
package lpfb_pkg;
  localparam int MaxPixels = 1024;
  localparam int MaxBpp = 8;
  localparam int TabDepth = 256;
  localparam int TabAw = 8;
  localparam int ColW = 24;

  localparam logic [3:0] PH_WIDTH   = 4'd0;
  localparam logic [3:0] PH_HEIGHT  = 4'd1;
  localparam logic [3:0] PH_BPP     = 4'd2;
  localparam logic [3:0] PH_PALETTE = 4'd3;
  localparam logic [3:0] PH_RGB     = 4'd4;
  localparam logic [3:0] PH_CHANGE  = 4'd5;
  localparam logic [3:0] PH_COUNT   = 4'd6;
  localparam logic [3:0] PH_UIDX    = 4'd7;
  localparam logic [3:0] PH_URED    = 4'd8;
  localparam logic [3:0] PH_UGREEN  = 4'd9;
  localparam logic [3:0] PH_UBLUE   = 4'd10;
  localparam logic [3:0] PH_INDEXED = 4'd11;
  localparam logic [3:0] PH_WAIT    = 4'd12;

  localparam logic [1:0] EV_PIXEL = 2'd0;
  localparam logic [1:0] EV_GRID  = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  // one result as handed from the parser to the output stage
  typedef struct packed {
    logic [1:0]  ev;
    logic [9:0]  idx;
    logic [23:0] rgb;
    logic [7:0]  gw;
    logic [7:0]  gh;
    logic        fe;
    logic        last;
  } lpfb_res_t;
endpackage
`default_nettype wire

### design/lpfb_ram.sv
// generic simple dual port ram (separate write and read addresses) with registered read
`timescale 1ns / 1ps
`default_nettype none
module lpfb_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/lpfb_parser.sv
// bit serial parser core, one stream bit per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none
module lpfb_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_byte,
  output logic            res_valid,
  input  wire logic       res_ready,
  output lpfb_pkg::lpfb_res_t res
);
  // byte state
  logic       busy_r, busy_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [2:0] bit_r, bit_nxt;
  // pending table lookup for an indexed pixel
  logic       look_r, look_nxt;
  logic       lend_r, lend_nxt;
  logic [9:0] lpos_r, lpos_nxt;
  logic [7:0] la_r, la_nxt;

  logic [3:0]  ph_r, ph_nxt;
  logic [7:0]  fw_r, fw_nxt, fh_r, fh_nxt;
  logic [3:0]  bpp_r, bpp_nxt;
  logic [10:0] ppf_r, ppf_nxt;
  logic [8:0]  psz_r, psz_nxt;
  logic [7:0]  pent_r, pent_nxt;
  logic [1:0]  pcomp_r, pcomp_nxt;
  logic [9:0]  pos_r, pos_nxt;
  logic [1:0]  cc_r, cc_nxt;
  logic [23:0] hc_r, hc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [3:0]  nb_r, nb_nxt;
  logic [7:0]  ul_r, ul_nxt;
  logic [7:0]  ui_r, ui_nxt;

  logic        we;
  logic [7:0]  waddr, raddr;
  logic [23:0] wdata, rdata;

  lpfb_ram #(.Width(lpfb_pkg::ColW), .Depth(lpfb_pkg::TabDepth)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic       stall;
  logic       emit_v;
  lpfb_pkg::lpfb_res_t emit;
  logic       res_v_r;
  lpfb_pkg::lpfb_res_t res_r;
  // newest result, held until it is known whether it ends its byte
  logic       cand_v_r;
  lpfb_pkg::lpfb_res_t cand_r;
  logic       out_free;
  logic       byte_done;
  logic       mv;

  assign out_free  = !res_v_r || res_ready;
  assign stall     = cand_v_r && !out_free;
  assign byte_done = !busy_r && !look_r;
  assign mv        = cand_v_r && out_free && (emit_v || byte_done);
  assign in_ready  = byte_done && !stall;
  assign res_valid = res_v_r;
  assign res       = res_r;

  // parse step: one bit per cycle when not stalled; a lookup result goes out from the registered table read
  always_comb begin
    logic [7:0]  sh1, v8, vb;
    logic [3:0]  nb1;
    logic        take8, takeb, lastbit;
    logic [15:0] tot;
    logic [10:0] pp1;
    busy_nxt = busy_r; byte_nxt = byte_r; bit_nxt = bit_r;
    look_nxt = 1'b0; lend_nxt = lend_r; lpos_nxt = lpos_r; la_nxt = la_r;
    ph_nxt = ph_r; fw_nxt = fw_r; fh_nxt = fh_r; bpp_nxt = bpp_r; ppf_nxt = ppf_r;
    psz_nxt = psz_r; pent_nxt = pent_r; pcomp_nxt = pcomp_r; pos_nxt = pos_r;
    cc_nxt = cc_r; hc_nxt = hc_r; sh_nxt = sh_r; nb_nxt = nb_r; ul_nxt = ul_r;
    ui_nxt = ui_r;
    we = 1'b0; waddr = pent_r; wdata = hc_r; raddr = la_r;
    emit_v = 1'b0;
    emit = '0;
    sh1 = {sh_r[6:0], byte_r[3'd7 - bit_r]};
    nb1 = nb_r + 4'd1;
    take8 = nb1 == 4'd8;
    v8 = sh1;
    takeb = (nb1 == bpp_r);
    vb = sh1 & ((8'd1 << bpp_r) - 8'd1);
    lastbit = bit_r == 3'd7;
    tot = 16'(fw_r) * 16'(fh_r);
    pp1 = 11'(pos_r) + 11'd1;
    if (stall) begin
      look_nxt = look_r;
    end else if (look_r) begin
      // finish an indexed pixel with the table data
      emit_v = 1'b1;
      emit.ev = lpfb_pkg::EV_PIXEL; emit.idx = lpos_r; emit.rgb = rdata;
      emit.fe = lend_r;
    end else if (!busy_r) begin
      if (in_valid) begin
        if (in_kind) begin
          ph_nxt = lpfb_pkg::PH_WIDTH; fw_nxt = '0; fh_nxt = '0; bpp_nxt = '0;
          ppf_nxt = '0; psz_nxt = '0; pent_nxt = '0; pcomp_nxt = '0; pos_nxt = '0;
          cc_nxt = '0; hc_nxt = '0; sh_nxt = '0; nb_nxt = '0; ul_nxt = '0; ui_nxt = '0;
        end else if (ph_r != lpfb_pkg::PH_WAIT) begin
          busy_nxt = 1'b1; byte_nxt = in_byte; bit_nxt = '0;
        end
      end
    end else begin
      sh_nxt = sh1; nb_nxt = nb1;
      unique case (ph_r)
        lpfb_pkg::PH_WIDTH, lpfb_pkg::PH_HEIGHT: if (take8) begin
          sh_nxt = '0; nb_nxt = '0;
          if (ph_r == lpfb_pkg::PH_WIDTH) begin
            fw_nxt = (v8 == 8'd0) ? 8'd1 : v8; ph_nxt = lpfb_pkg::PH_HEIGHT;
          end else begin
            fh_nxt = (v8 == 8'd0) ? 8'd1 : v8; ph_nxt = lpfb_pkg::PH_BPP;
          end
        end
        lpfb_pkg::PH_BPP: if (take8) begin
          sh_nxt = '0; nb_nxt = '0;
          bpp_nxt = v8[3:0];
          emit_v = 1'b1;
          if (v8 > 8'(lpfb_pkg::MaxBpp) || tot > 16'(lpfb_pkg::MaxPixels)) begin
            emit.ev = lpfb_pkg::EV_ERROR; ph_nxt = lpfb_pkg::PH_WAIT;
          end else begin
            emit.ev = lpfb_pkg::EV_GRID; emit.gw = fw_r; emit.gh = fh_r;
            ppf_nxt = tot[10:0];
            if (v8 == 8'd0) begin
              pos_nxt = '0; cc_nxt = '0; hc_nxt = '0; ph_nxt = lpfb_pkg::PH_RGB;
            end else begin
              psz_nxt = 9'd1 << v8[3:0]; pent_nxt = '0; pcomp_nxt = '0;
              ph_nxt = lpfb_pkg::PH_PALETTE;
            end
          end
        end
        lpfb_pkg::PH_PALETTE: if (take8) begin
          // colour built in held register, written on its third byte
          sh_nxt = '0; nb_nxt = '0;
          unique case (pcomp_r)
            2'd0: hc_nxt = {v8, hc_r[15:0]};
            2'd1: hc_nxt = {hc_r[23:16], v8, hc_r[7:0]};
            default: hc_nxt = {hc_r[23:8], v8};
          endcase
          if (pcomp_r == 2'd2) begin
            we = 1'b1; waddr = pent_r; wdata = {hc_r[23:8], v8};
            pcomp_nxt = '0; pent_nxt = pent_r + 8'd1;
            if (9'(pent_r) + 9'd1 >= psz_r) ph_nxt = lpfb_pkg::PH_CHANGE;
          end else pcomp_nxt = pcomp_r + 2'd1;
        end
        lpfb_pkg::PH_RGB: if (take8) begin
          sh_nxt = '0; nb_nxt = '0;
          if (cc_r == 2'd0) begin hc_nxt = {v8, hc_r[15:0]}; cc_nxt = 2'd1; end
          else if (cc_r == 2'd1) begin hc_nxt = {hc_r[23:16], v8, hc_r[7:0]}; cc_nxt = 2'd2; end
          else begin
            hc_nxt = {hc_r[23:8], v8}; cc_nxt = '0;
            emit_v = 1'b1; emit.ev = lpfb_pkg::EV_PIXEL; emit.idx = pos_r;
            emit.rgb = {hc_r[23:8], v8};
            emit.fe = pp1 >= ppf_r;
            pos_nxt = emit.fe ? 10'd0 : pp1[9:0];
          end
        end
        lpfb_pkg::PH_CHANGE: begin
          sh_nxt = '0; nb_nxt = '0;
          if (sh1[0]) ph_nxt = lpfb_pkg::PH_COUNT;
          else begin pos_nxt = '0; ph_nxt = lpfb_pkg::PH_INDEXED; end
        end
        lpfb_pkg::PH_COUNT: if (take8) begin
          sh_nxt = '0; nb_nxt = '0; ul_nxt = v8;
          if (v8 == 8'd0) begin pos_nxt = '0; ph_nxt = lpfb_pkg::PH_INDEXED; end
          else ph_nxt = lpfb_pkg::PH_UIDX;
        end
        lpfb_pkg::PH_UIDX: if (take8) begin
          sh_nxt = '0; nb_nxt = '0;
          if (9'(v8) >= psz_r) begin
            emit_v = 1'b1; emit.ev = lpfb_pkg::EV_ERROR; ph_nxt = lpfb_pkg::PH_WAIT;
          end else begin ui_nxt = v8; ph_nxt = lpfb_pkg::PH_URED; end
        end
        lpfb_pkg::PH_URED: if (take8) begin
          sh_nxt = '0; nb_nxt = '0; hc_nxt = {v8, hc_r[15:0]}; ph_nxt = lpfb_pkg::PH_UGREEN;
        end
        lpfb_pkg::PH_UGREEN: if (take8) begin
          sh_nxt = '0; nb_nxt = '0; hc_nxt = {hc_r[23:16], v8, hc_r[7:0]};
          ph_nxt = lpfb_pkg::PH_UBLUE;
        end
        lpfb_pkg::PH_UBLUE: if (take8) begin
          sh_nxt = '0; nb_nxt = '0; hc_nxt = {hc_r[23:8], v8};
          we = 1'b1; waddr = ui_r; wdata = {hc_r[23:8], v8};
          ul_nxt = ul_r - 8'd1;
          if (ul_r == 8'd1) begin pos_nxt = '0; ph_nxt = lpfb_pkg::PH_INDEXED; end
          else ph_nxt = lpfb_pkg::PH_UIDX;
        end
        lpfb_pkg::PH_INDEXED: if (takeb) begin
          // index always below palette size; read table, emit from the registered read data
          sh_nxt = '0; nb_nxt = '0;
          raddr = vb; la_nxt = vb;
          look_nxt = 1'b1; lpos_nxt = pos_r;
          lend_nxt = pp1 >= ppf_r;
          pos_nxt = pp1[9:0];
          if (lend_nxt) ph_nxt = lpfb_pkg::PH_CHANGE;
        end
        default: begin
          emit_v = 1'b1; emit.ev = lpfb_pkg::EV_ERROR; ph_nxt = lpfb_pkg::PH_WAIT;
        end
      endcase
      bit_nxt = bit_r + 3'd1;
      if (lastbit || ph_nxt == lpfb_pkg::PH_WAIT) busy_nxt = 1'b0;
    end
  end

  // parser state, held result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; look_r <= 1'b0; res_v_r <= 1'b0; ph_r <= lpfb_pkg::PH_WIDTH;
      fw_r <= '0; fh_r <= '0; bpp_r <= '0; ppf_r <= '0; psz_r <= '0; pent_r <= '0;
      pcomp_r <= '0; pos_r <= '0; cc_r <= '0; hc_r <= '0; sh_r <= '0; nb_r <= '0;
      ul_r <= '0; ui_r <= '0; cand_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; look_r <= look_nxt; ph_r <= ph_nxt;
      fw_r <= fw_nxt; fh_r <= fh_nxt; bpp_r <= bpp_nxt; ppf_r <= ppf_nxt;
      psz_r <= psz_nxt; pent_r <= pent_nxt; pcomp_r <= pcomp_nxt; pos_r <= pos_nxt;
      cc_r <= cc_nxt; hc_r <= hc_nxt; sh_r <= sh_nxt; nb_r <= nb_nxt;
      ul_r <= ul_nxt; ui_r <= ui_nxt;
      if (out_free) res_v_r <= mv;
      if (emit_v) cand_v_r <= 1'b1;
      else if (mv) cand_v_r <= 1'b0;
    end
  end

  // held result is last of its byte when the byte ends before another result
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt; bit_r <= bit_nxt; lend_r <= lend_nxt; lpos_r <= lpos_nxt;
    la_r <= la_nxt;
    if (emit_v) cand_r <= emit;
    if (mv) res_r <= {cand_r.ev, cand_r.idx, cand_r.rgb, cand_r.gw, cand_r.gh,
                      cand_r.fe, !emit_v};
  end
endmodule
`default_nettype wire

### design/led_palette_frame_bit_parser_unit.sv
// top level of the palette frame bit parser
`timescale 1ns / 1ps
`default_nettype none
// Palette LED frame parser. A data byte is accepted in an idle cycle and then
// worked one bit per cycle while the output does not stall, with an extra
// step for every indexed pixel read from the colour table ram; a silence
// request or a byte ignored after an error does not enter the bit loop.
// Each result waits in a hold register until the next result or the end of
// its byte shows whether it is the last of the byte, then leaves through a
// one-entry output register; with both full and the output stalled the bit
// loop and the input hold. The colour table holds no reset value: palette
// entries are valid once loaded.
module led_palette_frame_bit_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tuser,   // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // pixel_index, red, green, blue,
                                       // grid_width, grid_height, frame_end
  output logic [1:0]       out_tuser,  // event_res
  output logic             out_tlast   // item_last
);
  lpfb_pkg::lpfb_res_t res;

  lpfb_parser u_parser (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tuser), .in_byte(in_tdata), .res_valid(out_tvalid),
    .res_ready(out_tready), .res(res)
  );

  // pack result fields from the lowest bit up
  assign out_tdata = {5'd0, res.fe, res.gh, res.gw, res.rgb[7:0], res.rgb[15:8],
                      res.rgb[23:16], res.idx};
  assign out_tuser = res.ev;
  assign out_tlast = res.last;
endmodule
`default_nettype wire
